// File: hw/rtl/tpo_pkg.sv
// ----------------------------------------------------------------------------
// tpo_pkg: shared definitions for the triangle pair overlap test
// Stage numbering, geometry constants and the pipeline control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tpo_pkg;

  // Default coordinate width (Q12.4 at 16 bits).
  localparam int COORD_BITS_DEF = 16;

  // Geometry: two triangles, three vertices each, one axis per edge.
  localparam int TRI_VERTS = 3;
  localparam int NUM_VERTS = 2 * TRI_VERTS;
  localparam int NUM_AXES  = 2 * TRI_VERTS;

  // Pipeline stages.
  localparam int ST_IN     = 0;  // captured vertices
  localparam int ST_PROD   = 1;  // coordinate times axis component
  localparam int ST_PROJ   = 2;  // projections onto each axis
  localparam int ST_IVAL   = 3;  // min/max interval per triangle
  localparam int ST_OUT    = 4;  // result register
  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;      // stage captures new data this cycle
    logic [NUM_STAGES-1:0] valid;     // stage holds a live request
    logic                  in_stall;  // input side must hold its request
  } tpo_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/triangle_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_pair_overlap_test: 2D triangle pair overlap by separating axes
// Reports whether two triangles given in signed fixed point overlap.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request: the three vertices of each of
//   two triangles (a_* and b_*). It is taken at a clock edge where
//   in_valid_i is high and in_stall_o is low.
//   The output channel returns one collide_o bit per request, in order,
//   held while out_valid_o is high and out_stall_i is high.
//   Each edge normal of the two triangles is tested in its own unit; the pipeline is
//   input register, products, projections, intervals, result register.
//   Throughput: one request per cycle while out_stall_i is low; the stage registers bound the rate.
//   A stall on the output backs up stage by stage, so in_stall_o rises only
//   once every stage holds a request. While out_stall_i is low the input
//   never stalls.
//   Reset empties every stage; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_pair_overlap_test
  import tpo_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_x0_i,
  input  logic signed [COORD_BITS-1:0] a_y0_i,
  input  logic signed [COORD_BITS-1:0] a_x1_i,
  input  logic signed [COORD_BITS-1:0] a_y1_i,
  input  logic signed [COORD_BITS-1:0] a_x2_i,
  input  logic signed [COORD_BITS-1:0] a_y2_i,
  input  logic signed [COORD_BITS-1:0] b_x0_i,
  input  logic signed [COORD_BITS-1:0] b_y0_i,
  input  logic signed [COORD_BITS-1:0] b_x1_i,
  input  logic signed [COORD_BITS-1:0] b_y1_i,
  input  logic signed [COORD_BITS-1:0] b_x2_i,
  input  logic signed [COORD_BITS-1:0] b_y2_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         collide_o
);

  tpo_ctl_t ctl;

  logic signed [COORD_BITS-1:0] x_q [NUM_VERTS];
  logic signed [COORD_BITS-1:0] y_q [NUM_VERTS];
  logic [NUM_AXES-1:0]          sep;
  logic                         collide_q;

  tpo_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.load[ST_IN]) begin
      x_q[0] <= a_x0_i;
      y_q[0] <= a_y0_i;
      x_q[1] <= a_x1_i;
      y_q[1] <= a_y1_i;
      x_q[2] <= a_x2_i;
      y_q[2] <= a_y2_i;
      x_q[3] <= b_x0_i;
      y_q[3] <= b_y0_i;
      x_q[4] <= b_x1_i;
      y_q[4] <= b_y1_i;
      x_q[5] <= b_x2_i;
      y_q[5] <= b_y2_i;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    tpo_axis_unit #(
      .COORD_BITS (COORD_BITS),
      .AXIS       (a)
    ) u_axis (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .x_i   (x_q),
      .y_i   (y_q),
      .sep_o (sep[a])
    );
  end

  // The pair collides when no edge normal separates it.
  always_ff @(posedge clk_i) begin
    if (ctl.load[ST_OUT]) begin
      collide_q <= ~|sep;
    end
  end

  assign in_stall_o  = ctl.in_stall;
  assign out_valid_o = ctl.valid[ST_OUT];
  assign collide_o   = collide_q;

endmodule

`default_nettype wire

// File: hw/rtl/tpo_pipe_ctl.sv
// ----------------------------------------------------------------------------
// tpo_pipe_ctl: valid/stall control for the overlap test pipeline
// Tracks stage occupancy and produces per-stage load enables.
// ----------------------------------------------------------------------------
`default_nettype none

module tpo_pipe_ctl
  import tpo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_stall_i,
  output tpo_ctl_t ctl_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] load;

  // A stage can take new data when it is empty or its contents move on.
  assign rdy[NUM_STAGES] = ~out_stall_i;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    assign rdy[k] = ~valid_q[k] | rdy[k+1];
    if (k == 0) begin : g_first
      assign load[k]    = rdy[k] & in_valid_i;
      assign valid_d[k] = rdy[k] ? in_valid_i : valid_q[k];
    end else begin : g_rest
      assign load[k]    = rdy[k] & valid_q[k-1];
      assign valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.load     = load;
  assign ctl_o.valid    = valid_q;
  assign ctl_o.in_stall = ~rdy[0];

endmodule

`default_nettype wire

// File: hw/rtl/tpo_axis_unit.sv
// ----------------------------------------------------------------------------
// tpo_axis_unit: separation test along one edge normal
// Projects all six vertices onto the normal of one edge and checks whether
// the two triangles' intervals are disjoint.
// ----------------------------------------------------------------------------
`default_nettype none

module tpo_axis_unit
  import tpo_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS       = 0
) (
  input  logic                         clk_i,
  input  tpo_ctl_t                     ctl_i,
  input  logic signed [COORD_BITS-1:0] x_i [NUM_VERTS],
  input  logic signed [COORD_BITS-1:0] y_i [NUM_VERTS],
  output logic                         sep_o
);

  localparam int DW = COORD_BITS + 1;      // edge component
  localparam int PW = 2 * COORD_BITS + 1;  // single product
  localparam int SW = 2 * COORD_BITS + 2;  // dot product

  // Edge endpoints within the owning triangle.
  localparam int Base = (AXIS / TRI_VERTS) * TRI_VERTS;
  localparam int Es   = Base + (AXIS % TRI_VERTS);
  localparam int Ee   = Base + ((AXIS % TRI_VERTS) + 1) % TRI_VERTS;

  logic signed [DW-1:0] ax, ay;
  logic signed [PW-1:0] prod_x_q [NUM_VERTS];
  logic signed [PW-1:0] prod_y_q [NUM_VERTS];
  logic signed [SW-1:0] proj_q   [NUM_VERTS];
  logic signed [SW-1:0] lo_d [2], hi_d [2];
  logic signed [SW-1:0] lo_q [2], hi_q [2];

  // Normal of the edge: (-dy, dx).
  assign ax = DW'(y_i[Es]) - DW'(y_i[Ee]);
  assign ay = DW'(x_i[Ee]) - DW'(x_i[Es]);

  for (genvar i = 0; i < NUM_VERTS; i++) begin : g_vert
    always_ff @(posedge clk_i) begin
      if (ctl_i.load[ST_PROD]) begin
        prod_x_q[i] <= PW'(x_i[i]) * PW'(ax);
        prod_y_q[i] <= PW'(y_i[i]) * PW'(ay);
      end
      if (ctl_i.load[ST_PROJ]) begin
        proj_q[i] <= SW'(prod_x_q[i]) + SW'(prod_y_q[i]);
      end
    end
  end

  // All three pairwise compares run in parallel, then one selection.
  for (genvar t = 0; t < 2; t++) begin : g_tri
    logic signed [SW-1:0] p0, p1, p2;
    assign p0 = proj_q[t*TRI_VERTS];
    assign p1 = proj_q[t*TRI_VERTS+1];
    assign p2 = proj_q[t*TRI_VERTS+2];

    always_comb begin
      if (p0 <= p1 && p0 <= p2) begin
        lo_d[t] = p0;
      end else if (p1 <= p2) begin
        lo_d[t] = p1;
      end else begin
        lo_d[t] = p2;
      end
      if (p0 >= p1 && p0 >= p2) begin
        hi_d[t] = p0;
      end else if (p1 >= p2) begin
        hi_d[t] = p1;
      end else begin
        hi_d[t] = p2;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.load[ST_IVAL]) begin
        lo_q[t] <= lo_d[t];
        hi_q[t] <= hi_d[t];
      end
    end
  end

  // Touching intervals overlap; a zero axis gives all-zero intervals.
  assign sep_o = (hi_q[0] < lo_q[1]) || (hi_q[1] < lo_q[0]);

endmodule

`default_nettype wire

// File: hw/rtl/tpo_checker.sv
// ----------------------------------------------------------------------------
// tpo_checker: port-level checks for the triangle pair overlap test
// Watches the handshake and the result over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpo_checker
  import tpo_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic signed [COORD_BITS-1:0] a_x0_i,
  input logic signed [COORD_BITS-1:0] a_y0_i,
  input logic signed [COORD_BITS-1:0] a_x1_i,
  input logic signed [COORD_BITS-1:0] a_y1_i,
  input logic signed [COORD_BITS-1:0] a_x2_i,
  input logic signed [COORD_BITS-1:0] a_y2_i,
  input logic signed [COORD_BITS-1:0] b_x0_i,
  input logic signed [COORD_BITS-1:0] b_y0_i,
  input logic signed [COORD_BITS-1:0] b_x1_i,
  input logic signed [COORD_BITS-1:0] b_y1_i,
  input logic signed [COORD_BITS-1:0] b_x2_i,
  input logic signed [COORD_BITS-1:0] b_y2_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         collide_o
);

  logic in_take;
  logic tri_same;

  assign in_take  = in_valid_i && !in_stall_o;
  assign tri_same = a_x0_i == b_x0_i && a_y0_i == b_y0_i &&
                    a_x1_i == b_x1_i && a_y1_i == b_y1_i &&
                    a_x2_i == b_x2_i && a_y2_i == b_y2_i;

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(collide_o))
    else $error("stalled result dropped or changed");

  // With no result pending there is nothing to back up into the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  // Stalls only originate at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without an output stall");

  // Without output stalls a taken request yields a result, and a triangle
  // tested against itself always collides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o && (!$past(tri_same, 5) || collide_o))
    else $error("result late or identical triangles reported apart");

endmodule

bind triangle_pair_overlap_test tpo_checker #(.COORD_BITS(COORD_BITS)) u_tpo_checker (.*);

`default_nettype wire
